@@ sv/itp_pkg.sv @@
`default_nettype none

package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int PTR_W       = $clog2(STACK_DEPTH);

   localparam logic [7:0] CHR_EQ     = 8'h3d;
   localparam logic [7:0] CHR_OPEN   = 8'h28;
   localparam logic [7:0] CHR_CLOSE  = 8'h29;
   localparam logic [7:0] CHR_PLUS   = 8'h2b;
   localparam logic [7:0] CHR_MINUS  = 8'h2d;
   localparam logic [7:0] CHR_MUL    = 8'h2a;
   localparam logic [7:0] CHR_DIV    = 8'h2f;
   localparam logic [7:0] CHR_DIG_LO = 8'h30;
   localparam logic [7:0] CHR_DIG_HI = 8'h39;
   localparam logic [7:0] CHR_LOW_LO = 8'h61;
   localparam logic [7:0] CHR_LOW_HI = 8'h7a;
   localparam logic [7:0] CHR_UP_LO  = 8'h41;
   localparam logic [7:0] CHR_UP_HI  = 8'h5a;

   typedef enum logic [2:0] {
      CLS_IGNORE,
      CLS_OPERAND,
      CLS_OPEN,
      CLS_ADD,
      CLS_MUL,
      CLS_CLOSE,
      CLS_EQ
   } char_class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TOP,
      ST_FIN
   } state_type;

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type cls;
      cls = CLS_IGNORE;
      if ((c >= CHR_DIG_LO && c <= CHR_DIG_HI) || (c >= CHR_LOW_LO && c <= CHR_LOW_HI) ||
          (c >= CHR_UP_LO && c <= CHR_UP_HI)) begin
         cls = CLS_OPERAND;
      end else if (c == CHR_PLUS || c == CHR_MINUS) begin
         cls = CLS_ADD;
      end else if (c == CHR_MUL || c == CHR_DIV) begin
         cls = CLS_MUL;
      end else if (c == CHR_OPEN) begin
         cls = CLS_OPEN;
      end else if (c == CHR_CLOSE) begin
         cls = CLS_CLOSE;
      end else if (c == CHR_EQ) begin
         cls = CLS_EQ;
      end
      return cls;
   endfunction

endpackage

`default_nettype wire

@@ sv/itp_intf.sv @@
`default_nettype none

interface itp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink (input valid, input in_char, output ready);
endinterface

interface itp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;
   logic       overflow;

   modport source (output valid, output out_char, output last, output overflow, input ready);
   modport sink (input valid, input out_char, input last, input overflow, output ready);
endinterface

`default_nettype wire

@@ sv/infix_to_postfix_converter_core.sv @@
`default_nettype none

// channel | dir | payload                      | handshake
// req     | in  | in_char[7:0]                 | valid/ready
// rsp     | out | out_char[7:0], last, overflow | valid/ready
//
// Operands, ignored characters and '(' are handled in the idle state. Any other
// operator reads the stack top, then pops operators, one stack memory read
// each, until the stack empties or it reads a top entry that it does not
// emit; a '=' then emits its own character after the last popped operator.
// Synchronous reset empties the stack and clears the overflow flag.
// rsp is a registered beat; a stalled rsp holds the pop loop in place.

module infix_to_postfix_converter_core
   import itp_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   itp_req_if.sink     req,
   itp_rsp_if.source   rsp
);

   logic [7:0] mem [STACK_DEPTH];

   state_type      state_ff, state_in;
   char_class_type cls_ff, cls_in, req_cls;
   logic [7:0]     char_ff, char_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic           ovf_ff, ovf_in;
   logic [7:0]     pend_ff, pend_in;
   logic           pend_v_ff, pend_v_in;
   logic [7:0]     rd_ff;
   logic           rsp_valid_ff;
   logic [7:0]     rsp_char_ff;
   logic           rsp_last_ff;
   logic           rsp_ovf_ff;

   logic             rd_en, wr_en, do_push;
   logic [PTR_W-1:0] rd_addr, wr_addr;
   logic [7:0]       wr_data;
   logic             emit_en, emit_last;
   logic [7:0]       emit_char;
   logic             out_free, accept, pop_top, stall, full;
   logic [CNT_W-1:0] cnt_m1, cnt_m2;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign req_cls   = classify(req.in_char);
   assign stall     = pend_v_ff && !out_free;
   assign full      = (cnt_ff == CNT_W'(STACK_DEPTH));
   assign cnt_m1    = cnt_ff - CNT_W'(1);
   assign cnt_m2    = cnt_ff - CNT_W'(2);

   always_comb begin
      case (cls_ff) inside
         CLS_ADD, CLS_CLOSE: pop_top = (rd_ff != CHR_OPEN);
         CLS_MUL:            pop_top = (rd_ff == CHR_MUL) || (rd_ff == CHR_DIV);
         CLS_EQ:             pop_top = 1'b1;
         default:            pop_top = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cls) inside
                  CLS_ADD, CLS_MUL, CLS_CLOSE, CLS_EQ: begin
                     state_in = (cnt_ff != '0) ? ST_TOP : ST_FIN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_TOP: begin
            if (!stall) begin
               if (pop_top) begin
                  state_in = (cnt_ff == CNT_W'(1)) ? ST_FIN : ST_TOP;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (pend_v_ff) begin
               if (out_free) begin
                  state_in = (cls_ff == CLS_EQ) ? ST_FIN : ST_IDLE;
               end
            end else if (cls_ff == CLS_EQ) begin
               state_in = out_free ? ST_IDLE : ST_FIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      cls_in    = cls_ff;
      char_in   = char_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      rd_en     = 1'b0;
      rd_addr   = cnt_m1[PTR_W-1:0];
      do_push   = 1'b0;
      emit_en   = 1'b0;
      emit_char = pend_ff;
      emit_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cls_in  = req_cls;
               char_in = req.in_char;
               case (req_cls) inside
                  CLS_OPERAND: begin
                     emit_en   = 1'b1;
                     emit_char = req.in_char;
                     emit_last = 1'b1;
                  end
                  CLS_OPEN: do_push = 1'b1;
                  CLS_ADD, CLS_MUL, CLS_CLOSE, CLS_EQ: begin
                     rd_en = (cnt_ff != '0);
                  end
                  default: ;
               endcase
            end
         end
         ST_TOP: begin
            if (!stall) begin
               if (pop_top) begin
                  emit_en   = pend_v_ff;
                  pend_in   = rd_ff;
                  pend_v_in = 1'b1;
                  cnt_in    = cnt_m1;
                  rd_en     = (cnt_ff != CNT_W'(1));
                  rd_addr   = cnt_m2[PTR_W-1:0];
               end else if (cls_ff == CLS_CLOSE) begin
                  cnt_in = cnt_m1;
               end
            end
         end
         ST_FIN: begin
            if (pend_v_ff) begin
               if (out_free) begin
                  emit_en   = 1'b1;
                  emit_last = (cls_ff != CLS_EQ);
                  pend_v_in = 1'b0;
                  do_push   = (cls_ff == CLS_ADD) || (cls_ff == CLS_MUL);
               end
            end else if (cls_ff == CLS_EQ) begin
               if (out_free) begin
                  emit_en   = 1'b1;
                  emit_char = CHR_EQ;
                  emit_last = 1'b1;
                  ovf_in    = 1'b0;
               end
            end else begin
               do_push = (cls_ff == CLS_ADD) || (cls_ff == CLS_MUL);
            end
         end
         default: ;
      endcase
      if (do_push && full) begin
         ovf_in = 1'b1;
      end else if (do_push) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   assign wr_en   = do_push && !full;
   assign wr_addr = cnt_ff[PTR_W-1:0];
   assign wr_data = (state_ff == ST_IDLE) ? req.in_char : char_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         pend_v_ff <= pend_v_in;
         if (emit_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cls_ff  <= cls_in;
      char_ff <= char_in;
      pend_ff <= pend_in;
      if (emit_en) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= emit_last;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_char = rsp_char_ff;
   assign rsp.last     = rsp_last_ff;
   assign rsp.overflow = rsp_ovf_ff;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import itp_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_NEST     = 6;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       ovf;
   } postfix_beat_type;

   logic clock;
   logic reset;

   itp_req_if req_bus ();
   itp_rsp_if rsp_bus ();

   infix_to_postfix_converter_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   postfix_beat_type pending_postfix[$];
   logic [7:0]    opstack [STACK_DEPTH];
   int            opstack_depth = 0;
   logic          overflow_seen = 1'b0;

   int mismatches = 0;
   int cycle_cnt  = 0;
   int item_cnt   = 0;
   int idle_pct   = 0;
   int stall_pct  = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic void flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("ERROR cycle %0d: %s", cycle_cnt, what);
      end
   endfunction

   function automatic void emit_postfix(input logic [7:0] ch);
      postfix_beat_type beat;
      beat.ch   = ch;
      beat.last = 1'b0;
      beat.ovf  = overflow_seen;
      pending_postfix.push_back(beat);
   endfunction

   function automatic void push_op(input logic [7:0] ch);
      if (opstack_depth >= STACK_DEPTH) begin
         overflow_seen = 1'b1;
      end else begin
         opstack[PTR_W'(opstack_depth)] = ch;
         opstack_depth++;
      end
   endfunction

   function automatic logic [7:0] top_op();
      return opstack[PTR_W'(opstack_depth - 1)];
   endfunction

   function automatic void pop_emit();
      emit_postfix(top_op());
      opstack_depth--;
   endfunction

   // Returns 1 when the character is one the converter acts on.
   function automatic bit convert_char(input logic [7:0] c);
      int  base;
      bit  handled;
      base    = pending_postfix.size();
      handled = 1'b1;
      if ((c >= CHR_DIG_LO && c <= CHR_DIG_HI) || (c >= CHR_LOW_LO && c <= CHR_LOW_HI) ||
          (c >= CHR_UP_LO && c <= CHR_UP_HI)) begin
         emit_postfix(c);
      end else if (c == CHR_PLUS || c == CHR_MINUS) begin
         while (opstack_depth > 0 && top_op() != CHR_OPEN) pop_emit();
         push_op(c);
      end else if (c == CHR_MUL || c == CHR_DIV) begin
         while (opstack_depth > 0 && (top_op() == CHR_MUL || top_op() == CHR_DIV)) pop_emit();
         push_op(c);
      end else if (c == CHR_OPEN) begin
         push_op(c);
      end else if (c == CHR_CLOSE) begin
         while (opstack_depth > 0 && top_op() != CHR_OPEN) pop_emit();
         if (opstack_depth > 0) opstack_depth--;
      end else if (c == CHR_EQ) begin
         while (opstack_depth > 0) pop_emit();
         emit_postfix(c);
         overflow_seen = 1'b0;
      end else begin
         handled = 1'b0;
      end
      if (pending_postfix.size() > base) begin
         pending_postfix[pending_postfix.size() - 1].last = 1'b1;
      end
      return handled;
   endfunction

   always @(posedge clock) begin : rsp_check
      postfix_beat_type want;
      postfix_beat_type got;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.ch   = rsp_bus.out_char;
         got.last = rsp_bus.last;
         got.ovf  = rsp_bus.overflow;
         if (pending_postfix.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat char %h last %b overflow %b",
                                    got.ch, got.last, got.ovf));
         end else begin
            want = pending_postfix.pop_front();
            if (got !== want) begin
               flag_mismatch($sformatf(
                  "expected char %h last %b overflow %b, got char %h last %b overflow %b",
                  want.ch, want.last, want.ovf, got.ch, got.last, got.ovf));
            end
         end
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Call only right after a rising edge.
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_char <= c;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (convert_char(c)) item_cnt++;
   endtask

   function automatic logic [7:0] pick_operand();
      logic [7:0] ch;
      case ($urandom_range(0, 2))
         0:       ch = CHR_DIG_LO + 8'($urandom_range(0, 9));
         1:       ch = CHR_LOW_LO + 8'($urandom_range(0, 25));
         default: ch = CHR_UP_LO + 8'($urandom_range(0, 25));
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] pick_operator();
      logic [7:0] ch;
      case ($urandom_range(0, 3))
         0:       ch = CHR_PLUS;
         1:       ch = CHR_MINUS;
         2:       ch = CHR_MUL;
         default: ch = CHR_DIV;
      endcase
      return ch;
   endfunction

   task automatic test_operands();
      send_char(CHR_DIG_LO);
      send_char(CHR_DIG_HI);
      send_char(CHR_LOW_LO);
      send_char(CHR_LOW_HI);
      send_char(CHR_UP_LO);
      send_char(CHR_UP_HI);
   endtask

   task automatic test_precedence();
      logic [7:0] seq [14];
      seq = '{CHR_OPEN, "a", CHR_PLUS, "b", CHR_CLOSE, CHR_MUL, "c", CHR_MINUS,
              "d", CHR_DIV, "e", CHR_MUL, "f", CHR_EQ};
      foreach (seq[i]) send_char(seq[i]);
   endtask

   task automatic test_odd_chars();
      send_char(8'h00);
      send_char(8'hff);
      send_char(CHR_PLUS);
      send_char(CHR_CLOSE);
      send_char(CHR_CLOSE);
      send_char(CHR_EQ);
   endtask

   task automatic test_stack_overflow();
      int extra;
      extra = $urandom_range(1, 4);
      repeat (STACK_DEPTH + extra) begin
         send_char(CHR_OPEN);
         if ($urandom_range(0, 2) == 0) send_char(pick_operand());
      end
      send_char(pick_operator());
      send_char(pick_operand());
      send_char(pick_operator());
      send_char(pick_operand());
      send_char(CHR_CLOSE);
      send_char(CHR_EQ);
      send_char(pick_operand());
      send_char(CHR_EQ);
   endtask

   task automatic send_random_expression();
      int terms;
      int open_cnt;
      terms    = $urandom_range(1, 8);
      open_cnt = 0;
      for (int i = 0; i < terms; i++) begin
         while (open_cnt < MAX_NEST && $urandom_range(0, 3) == 0) begin
            send_char(CHR_OPEN);
            open_cnt++;
         end
         send_char(pick_operand());
         while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
            send_char(CHR_CLOSE);
            open_cnt--;
         end
         if (i < terms - 1) send_char(pick_operator());
         if ($urandom_range(0, 15) == 0) send_char(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 19) == 0) send_char(CHR_CLOSE);
         if ($urandom_range(0, 19) == 0) send_char(pick_operator());
      end
      while (open_cnt > 0) begin
         send_char(CHR_CLOSE);
         open_cnt--;
      end
      if ($urandom_range(0, 9) != 0) send_char(CHR_EQ);
   endtask

   task automatic test_random_expressions(input int target);
      int start;
      start = item_cnt;
      while (item_cnt - start < target) send_random_expression();
   endtask

   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.in_char <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_operands();
      test_precedence();
      test_odd_chars();
      test_random_expressions(18);

      idle_pct = 61;
      test_random_expressions(18);

      idle_pct  = 0;
      stall_pct = 61;
      test_random_expressions(18);

      idle_pct  = 28;
      stall_pct = 28;
      test_stack_overflow();
      test_random_expressions(18);

      req_bus.valid <= 1'b0;
      while (pending_postfix.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
